>>> rtl/core/nra_pkg.sv
// nra_pkg: shared constants, types and ring-neighbor helpers for the
// neighbor resource arbiter. No dependencies.
package nra_pkg;

    localparam int MAX_PARTIES = 16;
    localparam int PARTY_W     = $clog2(MAX_PARTIES);
    localparam int RING_W      = $clog2(MAX_PARTIES + 1);
    localparam int RING_MIN    = 2;
    localparam int RING_RESET  = (MAX_PARTIES < 16) ? MAX_PARTIES : 16;
    localparam int TDATA_W     = ((PARTY_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_REQUEST = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [PARTY_W-1:0] party;
    } cmd_item_t;

    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } push_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_APPLY,
        BK_LEFT,
        BK_RIGHT,
        BK_EMIT
    } back_state_t;

    function automatic logic [PARTY_W-1:0] left_of(input logic [PARTY_W-1:0] p,
                                                   input logic [RING_W-1:0] n);
        logic [RING_W-1:0] nm1;
        nm1 = n - RING_W'(1);
        return (p == '0) ? nm1[PARTY_W-1:0] : p - PARTY_W'(1);
    endfunction

    function automatic logic [PARTY_W-1:0] right_of(input logic [PARTY_W-1:0] p,
                                                    input logic [RING_W-1:0] n);
        logic [RING_W-1:0] pp1;
        pp1 = RING_W'(p) + RING_W'(1);
        return (pp1 >= n) ? '0 : pp1[PARTY_W-1:0];
    endfunction

endpackage

>>> rtl/core/nra_front.sv
// nra_front: input side of the arbiter. Accepts items, drops commands for
// parties outside the ring, and pushes the rest into the command queue.
// Depends on nra_pkg.
module nra_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nra_pkg::TDATA_W-1:0] s_tdata,   // [3:0] party
    input  logic                        s_tuser,   // [0] cmd
    input  logic [nra_pkg::RING_W-1:0]  ring_size,
    input  logic                        q_full,
    output nra_pkg::push_t              push
);

    logic                        accept;
    logic [nra_pkg::PARTY_W-1:0] party;
    logic                        in_range;

    assign party    = s_tdata[nra_pkg::PARTY_W-1:0];
    assign in_range = (nra_pkg::RING_W'(party) < ring_size);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // out-of-range commands are swallowed here
    assign push.valid      = accept && in_range;
    assign push.item.cmd   = nra_pkg::cmd_t'(s_tuser);
    assign push.item.party = party;

endmodule

>>> rtl/core/nra_queue.sv
// nra_queue: short command queue between front and back.
// Depends on nra_pkg.
module nra_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  nra_pkg::push_t      push,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output nra_pkg::cmd_item_t  head
);

    nra_pkg::cmd_item_t              mem_reg [nra_pkg::QUEUE_DEPTH];
    logic [nra_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [nra_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [nra_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (cnt_reg == nra_pkg::QCNT_W'(nra_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == nra_pkg::QPTR_W'(nra_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + nra_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == nra_pkg::QPTR_W'(nra_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + nra_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + nra_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - nra_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

>>> rtl/core/nra_back.sv
// nra_back: executes queued commands against the party state bitmaps and
// drives the result channel through an output register. Depends on nra_pkg.
module nra_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [nra_pkg::RING_W-1:0]  ring_size,
    input  logic                        q_empty,
    input  nra_pkg::cmd_item_t          q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nra_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    nra_pkg::back_state_t             state_reg, state_next;
    logic [nra_pkg::MAX_PARTIES-1:0]  wait_reg, wait_next;
    logic [nra_pkg::MAX_PARTIES-1:0]  grant_reg, grant_next;
    nra_pkg::cmd_item_t               cur_reg, cur_next;
    logic [nra_pkg::PARTY_W-1:0]      res_party_reg [2];
    logic [nra_pkg::PARTY_W-1:0]      res_party_next [2];
    logic [1:0]                       res_cnt_reg, res_cnt_next;
    logic                             emit_idx_reg, emit_idx_next;
    logic                             m_valid_reg, m_valid_next;
    logic [nra_pkg::PARTY_W-1:0]      m_party_reg, m_party_next;
    logic                             m_last_reg, m_last_next;

    logic [nra_pkg::PARTY_W-1:0]      left_p;
    logic [nra_pkg::PARTY_W-1:0]      right_p;
    logic [nra_pkg::PARTY_W-1:0]      target;
    logic                             nbr_free;
    logic                             try_ok;
    logic                             req_idle;
    logic                             out_free;
    logic                             last_emit;

    assign left_p  = nra_pkg::left_of(cur_reg.party, ring_size);
    assign right_p = nra_pkg::right_of(cur_reg.party, ring_size);

    always_comb begin
        case (state_reg)
            nra_pkg::BK_LEFT:  target = left_p;
            nra_pkg::BK_RIGHT: target = right_p;
            default:           target = cur_reg.party;
        endcase
    end

    // one shared grant check for whichever party the step looks at
    assign nbr_free  = !grant_reg[nra_pkg::left_of(target, ring_size)] &&
                       !grant_reg[nra_pkg::right_of(target, ring_size)];
    assign try_ok    = wait_reg[target] && nbr_free;
    assign req_idle  = !wait_reg[cur_reg.party] && !grant_reg[cur_reg.party];
    assign out_free  = !m_valid_reg || m_tready;
    assign last_emit = ({1'b0, emit_idx_reg} == (res_cnt_reg - 2'd1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nra_pkg::BK_IDLE: begin
                if (!q_empty) state_next = nra_pkg::BK_APPLY;
            end
            nra_pkg::BK_APPLY: begin
                if (cur_reg.cmd == nra_pkg::CMD_REQUEST) begin
                    state_next = (req_idle && nbr_free) ? nra_pkg::BK_EMIT : nra_pkg::BK_IDLE;
                end else begin
                    state_next = grant_reg[cur_reg.party] ? nra_pkg::BK_LEFT : nra_pkg::BK_IDLE;
                end
            end
            nra_pkg::BK_LEFT: begin
                state_next = nra_pkg::BK_RIGHT;
            end
            nra_pkg::BK_RIGHT: begin
                state_next = (res_cnt_reg != 2'd0 || try_ok) ? nra_pkg::BK_EMIT
                                                             : nra_pkg::BK_IDLE;
            end
            nra_pkg::BK_EMIT: begin
                if (out_free && last_emit) state_next = nra_pkg::BK_IDLE;
            end
            default: begin
                state_next = nra_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        wait_next         = wait_reg;
        grant_next        = grant_reg;
        cur_next          = cur_reg;
        res_party_next[0] = res_party_reg[0];
        res_party_next[1] = res_party_reg[1];
        res_cnt_next      = res_cnt_reg;
        emit_idx_next     = emit_idx_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_party_next      = m_party_reg;
        m_last_next       = m_last_reg;
        q_pop             = 1'b0;
        case (state_reg)
            nra_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop         = 1'b1;
                    cur_next      = q_head;
                    res_cnt_next  = 2'd0;
                    emit_idx_next = 1'b0;
                end
            end
            nra_pkg::BK_APPLY: begin
                if (cur_reg.cmd == nra_pkg::CMD_REQUEST) begin
                    if (req_idle) begin
                        if (nbr_free) begin
                            grant_next[cur_reg.party]     = 1'b1;
                            res_party_next[res_cnt_reg[0]] = target;
                            res_cnt_next                  = res_cnt_reg + 2'd1;
                        end else begin
                            wait_next[cur_reg.party] = 1'b1;
                        end
                    end
                end else if (grant_reg[cur_reg.party]) begin
                    grant_next[cur_reg.party] = 1'b0;
                end
            end
            nra_pkg::BK_LEFT, nra_pkg::BK_RIGHT: begin
                if (try_ok) begin
                    wait_next[target]              = 1'b0;
                    grant_next[target]             = 1'b1;
                    res_party_next[res_cnt_reg[0]] = target;
                    res_cnt_next                   = res_cnt_reg + 2'd1;
                end
            end
            nra_pkg::BK_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_party_next  = res_party_reg[emit_idx_reg];
                    m_last_next   = last_emit;
                    emit_idx_next = !emit_idx_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= nra_pkg::BK_IDLE;
            wait_reg     <= '0;
            grant_reg    <= '0;
            res_cnt_reg  <= 2'd0;
            emit_idx_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            grant_reg    <= grant_next;
            res_cnt_reg  <= res_cnt_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg          <= cur_next;
        res_party_reg[0] <= res_party_next[0];
        res_party_reg[1] <= res_party_next[1];
        m_party_reg      <= m_party_next;
        m_last_reg       <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = nra_pkg::TDATA_W'(m_party_reg);
    assign m_tlast  = m_last_reg;

    // a party is never waiting and granted at once
    a_wait_grant_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(|(wait_reg & grant_reg)))
        else $error("party both waiting and granted");

    a_emit_has_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nra_pkg::BK_EMIT) |-> (res_cnt_reg == 2'd1 || res_cnt_reg == 2'd2))
        else $error("emit phase with no results");

    a_final_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nra_pkg::BK_EMIT && out_free && last_emit) |=>
        (state_reg == nra_pkg::BK_IDLE && m_tvalid && m_tlast))
        else $error("final result not marked last");

    a_left_grant_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nra_pkg::BK_LEFT && try_ok) |=> grant_reg[$past(target)])
        else $error("left neighbor grant lost");

endmodule

>>> rtl/core/neighbor_resource_arbiter_unit.sv
// neighbor_resource_arbiter_unit: top level of the ring neighbor arbiter.
// Instantiates nra_front, nra_queue and nra_back; depends on nra_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata[3:0] party, s_tuser cmd
//  m_      | out       | m_tvalid/m_tready  | m_tdata[3:0] granted_party,
//          |           |                    | m_tlast final grant of the item
//  cfg_    | in        | cfg_we             | cfg_wdata[4:0] num_parties
//
// Sequencing: the back end handles one command at a time. A request steps
// through dequeue and apply, then emits its grant if any; a release steps
// through dequeue, apply, left check and right check, then emits each grant,
// waiting on m_tready as needed. The back end sequencer walks the neighbors
// one at a time through a single grant check.
// Reset: aresetn synchronous active low; all parties idle, num_parties = 16.
// Stalls: the 2-entry queue lets the front keep accepting items while the back
// waits on m_tready; results leave through a registered output stage.
module neighbor_resource_arbiter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [nra_pkg::TDATA_W-1:0] s_tdata,   // [3:0] party, [7:4] zero
    input  logic                        s_tuser,   // [0] cmd: 0 request, 1 release
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [nra_pkg::TDATA_W-1:0] m_tdata,   // [3:0] granted_party, [7:4] zero
    output logic                        m_tlast,
    // configuration
    input  logic                        cfg_we,
    input  logic [nra_pkg::RING_W-1:0]  cfg_wdata
);

    logic [nra_pkg::RING_W-1:0] num_parties_reg;
    logic [nra_pkg::RING_W-1:0] ring_size;
    nra_pkg::push_t             push;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    nra_pkg::cmd_item_t         q_head;

    // raw register keeps its bits; use is clamped to the legal ring range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_parties_reg <= nra_pkg::RING_W'(nra_pkg::RING_RESET);
        end else if (cfg_we) begin
            num_parties_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (num_parties_reg < nra_pkg::RING_W'(nra_pkg::RING_MIN)) begin
            ring_size = nra_pkg::RING_W'(nra_pkg::RING_MIN);
        end else if (num_parties_reg > nra_pkg::RING_W'(nra_pkg::MAX_PARTIES)) begin
            ring_size = nra_pkg::RING_W'(nra_pkg::MAX_PARTIES);
        end else begin
            ring_size = num_parties_reg;
        end
    end

    // front: accept and screen
    nra_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ring_size (ring_size),
        .q_full    (q_full),
        .push      (push)
    );

    // decoupling queue
    nra_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .head    (q_head)
    );

    // back: state update and grants
    nra_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ring_size (ring_size),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for neighbor_resource_arbiter_unit.
// A grant scoreboard tracks every party's state and predicts each grant item.
// Depends on rtl/core/nra_pkg.sv and the arbiter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PS_IDLE    = 2'd0,
        PS_WAITING = 2'd1,
        PS_GRANTED = 2'd2
    } party_state_t;

    typedef struct {
        logic [3:0] party;
        logic       last;
    } grant_t;

    // Tracks the ring and queues the grants that each accepted command causes.
    class grant_scoreboard;
        party_state_t state[16];
        logic [4:0]   ring_reg;
        grant_t       grants_due[$];
        int           errors;

        function new();
            foreach (state[i]) state[i] = PS_IDLE;
            ring_reg = 5'd16;
            errors   = 0;
        endfunction

        function void set_ring(logic [4:0] v);
            ring_reg = v;
        endfunction

        // Raw register saturates to 2..16 parties.
        function int ring_size();
            if (ring_reg < 2) return 2;
            if (ring_reg > 16) return 16;
            return ring_reg;
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        // Random granted party inside the ring, or -1 if none.
        function int pick_granted();
            int cand[$];
            int n;
            n = ring_size();
            for (int i = 0; i < n; i++)
                if (state[i] == PS_GRANTED) cand.push_back(i);
            if (cand.size() == 0) return -1;
            return cand[$urandom_range(0, cand.size() - 1)];
        endfunction

        function bit can_grant(int p, int n);
            int lft;
            int rgt;
            lft = (p == 0) ? n - 1 : p - 1;
            rgt = (p + 1 >= n) ? 0 : p + 1;
            if (state[p] != PS_WAITING) return 0;
            if (state[lft] == PS_GRANTED || state[rgt] == PS_GRANTED) return 0;
            state[p] = PS_GRANTED;
            return 1;
        endfunction

        function void note_command(nra_pkg::cmd_t cmd, logic [3:0] party);
            int     n;
            int     p;
            int     cnt;
            int     hit[2];
            grant_t g;
            n   = ring_size();
            p   = party;
            cnt = 0;
            if (p >= n) return;
            if (cmd == nra_pkg::CMD_REQUEST) begin
                if (state[p] != PS_IDLE) return;
                state[p] = PS_WAITING;
                if (can_grant(p, n)) begin
                    hit[cnt] = p;
                    cnt++;
                end
            end else begin
                if (state[p] != PS_GRANTED) return;
                state[p] = PS_IDLE;
                // left neighbor is checked first, then right
                if (can_grant((p == 0) ? n - 1 : p - 1, n)) begin
                    hit[cnt] = (p == 0) ? n - 1 : p - 1;
                    cnt++;
                end
                if (can_grant((p + 1 >= n) ? 0 : p + 1, n)) begin
                    hit[cnt] = (p + 1 >= n) ? 0 : p + 1;
                    cnt++;
                end
            end
            for (int k = 0; k < cnt; k++) begin
                g.party = hit[k][3:0];
                g.last  = (k == cnt - 1);
                grants_due.push_back(g);
            end
        endfunction

        function void check_grant(logic [3:0] party, logic last);
            grant_t g;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected grant item, expected none, actual party %0d last %0b",
                         $time, party, last);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (party !== g.party) begin
                $display("%0t: granted_party mismatch, expected %0d actual %0d",
                         $time, g.party, party);
                errors++;
            end
            if (last !== g.last) begin
                $display("%0t: last mismatch, expected %0b actual %0b",
                         $time, g.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int DRAIN_CYCLES = 32;      // covers queue plus sequencer latency
    localparam int LONG_HOLD    = 300;     // receiver hold-off for back pressure

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [nra_pkg::TDATA_W-1:0] s_tdata;
    logic                        s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [nra_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;
    logic                        cfg_we;
    logic [nra_pkg::RING_W-1:0]  cfg_wdata;

    grant_scoreboard sb;
    bit              hold_req;   // set by stimulus, cleared by the receiver
    bit              no_gaps;    // sender burst mode

    neighbor_resource_arbiter_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Run limit: well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("** neighbor_resource_arbiter_unit: FAILED **");
        $finish;
    end

    // Result monitor, sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_grant(m_tdata[3:0], m_tlast);
    end

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin
        int r;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_req = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(0, 20)) @(negedge aclk);
                end else if (r < 92) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(0, 2)) @(negedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(negedge aclk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one command item; called and returns at a falling edge.
    // Valid stays high when the next item follows without a gap.
    task automatic send_cmd(nra_pkg::cmd_t cmd, logic [3:0] party);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= nra_pkg::TDATA_W'(party);
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, party);
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Idle wait: all grants in, then room for commands that cause none.
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Called at a falling edge with the input channel idle.
    task automatic write_ring(logic [4:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_ring(v);
    endtask

    // Mostly legal traffic: requests in the ring, releases of granted
    // parties; some noise with any party and any command.
    task automatic send_random();
        int            r;
        int            n;
        int            g;
        nra_pkg::cmd_t cmd;
        logic [3:0]    party;
        r = $urandom_range(0, 99);
        n = sb.ring_size();
        if (r < 12) begin
            cmd   = nra_pkg::cmd_t'($urandom_range(0, 1));
            party = 4'($urandom_range(0, 15));
        end else if (r < 55) begin
            cmd   = nra_pkg::CMD_REQUEST;
            party = 4'($urandom_range(0, n - 1));
        end else begin
            cmd = nra_pkg::CMD_RELEASE;
            g   = sb.pick_granted();
            if (g >= 0 && $urandom_range(0, 4) != 0) party = 4'(g);
            else party = 4'($urandom_range(0, n - 1));
        end
        send_cmd(cmd, party);
    endtask

    initial begin
        logic [4:0] ring_plan[10];
        sb        = new();
        hold_req  = 0;
        no_gaps   = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset ring of 16.
        send_cmd(nra_pkg::CMD_REQUEST, 4'd0);    // granted at once
        send_cmd(nra_pkg::CMD_REQUEST, 4'd1);    // waits on party 0
        send_cmd(nra_pkg::CMD_REQUEST, 4'd15);   // waits on party 0, wraps left
        send_cmd(nra_pkg::CMD_REQUEST, 4'd0);    // request while granted: ignored
        send_cmd(nra_pkg::CMD_RELEASE, 4'd1);    // release while waiting: ignored
        send_cmd(nra_pkg::CMD_RELEASE, 4'd0);    // two grants, left then right
        send_cmd(nra_pkg::CMD_RELEASE, 4'd15);
        send_cmd(nra_pkg::CMD_RELEASE, 4'd1);
        send_cmd(nra_pkg::CMD_RELEASE, 4'd7);    // release while idle: ignored
        send_cmd(nra_pkg::CMD_REQUEST, 4'd14);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd15);   // waits on party 14
        send_cmd(nra_pkg::CMD_RELEASE, 4'd14);   // grants right neighbor 15
        send_cmd(nra_pkg::CMD_RELEASE, 4'd15);
        s_tvalid <= 1'b0;
        wait_idle();

        // Two-party ring: both neighbors are one party.
        write_ring(5'd2);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd0);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd1);
        send_cmd(nra_pkg::CMD_RELEASE, 4'd0);    // only one grant
        send_cmd(nra_pkg::CMD_RELEASE, 4'd1);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd5);    // outside the ring: ignored
        s_tvalid <= 1'b0;
        wait_idle();

        // Below minimum acts as two; above maximum acts as sixteen.
        write_ring(5'd0);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd1);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd2);    // outside the ring: ignored
        s_tvalid <= 1'b0;
        wait_idle();
        write_ring(5'd31);
        send_cmd(nra_pkg::CMD_REQUEST, 4'd15);   // state kept across the size change
        send_cmd(nra_pkg::CMD_RELEASE, 4'd1);
        send_cmd(nra_pkg::CMD_RELEASE, 4'd15);
        s_tvalid <= 1'b0;
        wait_idle();

        // Random phases over several ring sizes.
        ring_plan = '{5'd3, 5'd16, 5'd5, 5'd1, 5'd17, 5'd2, 5'd31, 5'd7, 5'd0, 5'd16};
        for (int ph = 0; ph < 10; ph++) begin
            write_ring((ph == 9) ? 5'($urandom_range(0, 31)) : ring_plan[ph]);
            no_gaps = (ph == 1 || ph == 4);
            if (ph == 1) hold_req = 1;  // fill the block while results back up
            for (int i = 0; i < 70; i++) send_random();
            s_tvalid <= 1'b0;
            no_gaps = 0;
            wait_idle();
        end

        if (sb.errors == 0)
            $display("** neighbor_resource_arbiter_unit: PASSED **");
        else
            $display("** neighbor_resource_arbiter_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/nra_pkg.sv
rtl/core/nra_front.sv
rtl/core/nra_queue.sv
rtl/core/nra_back.sv
rtl/core/neighbor_resource_arbiter_unit.sv
sim/testbench.sv
